FILE: design/cln_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cln_pkg: shared types and constants for the character LCD nibble writer
// Holds the operation codes, the byte entry that goes from front to back,
// the DDRAM row offsets and the set-address helper.
// ----------------------------------------------------------------------------
package cln_pkg;

  localparam int unsigned DefColumns = 16;
  localparam int unsigned DefRows    = 2;

  // Depth of the byte queue between the front and the back.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  typedef enum logic [1:0] {
    OP_TEXT    = 2'd0,
    OP_SET_CUR = 2'd1,
    OP_RAW_CMD = 2'd2,
    OP_RAW_DAT = 2'd3
  } op_e;

  localparam logic [7:0] CharLf = 8'h0A;
  localparam logic [7:0] CharCr = 8'h0D;

  localparam logic RsInstr = 1'b0;
  localparam logic RsData  = 1'b1;

  localparam logic [7:0] SetAddrCmd = 8'h80;

  localparam logic [6:0] RowBase [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

  // One byte for the bus, with its register select and end-of-item mark.
  typedef struct packed {
    logic       rs;
    logic [7:0] value;
    logic       last;
  } byte_entry_t;

  // Set-address instruction byte: address is taken modulo 128.
  function automatic logic [7:0] set_addr(logic [5:0] col, logic [1:0] row);
    logic [6:0] sum;
    sum = {1'b0, col} + RowBase[row];
    return SetAddrCmd | {1'b0, sum};
  endfunction

endpackage : cln_pkg
`default_nettype wire

FILE: design/cln_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cln_front: item intake and cursor tracking
// Accepts items, updates the cursor and turns each item into one or two
// bytes for the byte queue. A second byte waits in a holding register.
// ----------------------------------------------------------------------------
module cln_front import cln_pkg::*; #(
  parameter int unsigned COLUMNS = DefColumns,
  parameter int unsigned ROWS    = DefRows
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  operation_i,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic [5:0]  target_column_i,
  input  wire logic [2:0]  target_row_i,
  output logic             q_push_o,
  output byte_entry_t      q_entry_o,
  input  wire logic        q_full_i
);

  localparam logic [5:0] ColLimit = 6'(COLUMNS);
  localparam logic [2:0] RowLimit = 3'(ROWS);

  logic [5:0]  col_q, col_d;
  logic [1:0]  row_q, row_d;
  logic        pend_valid_q, pend_valid_d;
  byte_entry_t pend_q;

  logic        accept;
  logic        two;
  byte_entry_t first_e, second_e;
  logic        wrap;
  logic [5:0]  col_w;
  logic [1:0]  row_w, row_nl, row_set;
  op_e         op;

  function automatic logic [1:0] next_row(logic [1:0] row);
    logic [2:0] inc;
    inc = {1'b0, row} + 3'd1;
    return (inc >= RowLimit) ? 2'd0 : inc[1:0];
  endfunction

  assign op     = op_e'(operation_i);
  assign full   = pend_valid_q || q_full_i;
  assign accept = push && !full;

  always_comb begin
    wrap    = (op == OP_TEXT) && (col_q >= ColLimit);
    col_w   = wrap ? 6'd0 : col_q;
    row_w   = wrap ? next_row(row_q) : row_q;
    row_nl  = next_row(row_w);
    row_set = (target_row_i >= RowLimit) ? 2'd0 : target_row_i[1:0];

    col_d    = col_q;
    row_d    = row_q;
    two      = 1'b0;
    first_e  = '{rs: RsInstr, value: set_addr(6'd0, row_w), last: 1'b0};
    second_e = '{rs: RsData, value: byte_value_i, last: 1'b1};

    unique case (op)
      OP_TEXT: begin
        if (byte_value_i == CharLf) begin
          second_e = '{rs: RsInstr, value: set_addr(col_w, row_nl), last: 1'b1};
          col_d    = col_w;
          row_d    = row_nl;
        end else if (byte_value_i == CharCr) begin
          second_e = '{rs: RsInstr, value: set_addr(6'd0, row_w), last: 1'b1};
          col_d    = 6'd0;
          row_d    = row_w;
        end else begin
          second_e = '{rs: RsData, value: byte_value_i, last: 1'b1};
          col_d    = col_w + 6'd1;
          row_d    = row_w;
        end
        // Without a wrap the single byte is the one built above.
        if (wrap) begin
          two = 1'b1;
        end else begin
          first_e = second_e;
        end
      end
      OP_SET_CUR: begin
        first_e = '{rs: RsInstr, value: set_addr(target_column_i, row_set), last: 1'b1};
        col_d   = target_column_i;
        row_d   = row_set;
      end
      OP_RAW_CMD: begin
        first_e = '{rs: RsInstr, value: byte_value_i, last: 1'b1};
      end
      OP_RAW_DAT: begin
        first_e = '{rs: RsData, value: byte_value_i, last: 1'b1};
      end
      default: begin
        first_e = '{rs: RsData, value: byte_value_i, last: 1'b1};
      end
    endcase
  end

  assign q_push_o  = pend_valid_q ? !q_full_i : accept;
  assign q_entry_o = pend_valid_q ? pend_q : first_e;

  always_comb begin
    if (pend_valid_q) begin
      pend_valid_d = q_full_i;
    end else begin
      pend_valid_d = accept && two;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && two) begin
      pend_q <= second_e;
    end
  end

endmodule : cln_front
`default_nettype wire

FILE: design/cln_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cln_queue: byte queue between front and back
// A small circular buffer of byte entries with an occupancy count.
// ----------------------------------------------------------------------------
module cln_queue import cln_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire byte_entry_t entry_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output byte_entry_t      entry_o,
  output logic             empty_o
);

  localparam logic [QPtrW:0] CountMax = (QPtrW + 1)'(QDepth);
  localparam logic [QPtrW-1:0] PtrLast = QPtrW'(QDepth - 1);

  byte_entry_t       mem_q [QDepth];
  logic [QPtrW-1:0]  wr_q, rd_q;
  logic [QPtrW:0]    count_q;

  assign full_o  = (count_q == CountMax);
  assign empty_o = (count_q == '0);
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule : cln_queue
`default_nettype wire

FILE: design/cln_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cln_back: nibble serializer
// Takes byte entries from the queue and sends each one as two nibble
// transfers, high nibble first, through an output register.
// ----------------------------------------------------------------------------
module cln_back import cln_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire byte_entry_t q_entry_i,
  input  wire logic        q_empty_i,
  output logic             q_pop_o,
  output logic             empty,
  input  wire logic        pop,
  output logic             register_select_o,
  output logic [3:0]       nibble_o,
  output logic             last_o
);

  byte_entry_t cur_q;
  logic        cur_valid_q, cur_valid_d;
  logic        phase_q, phase_d;
  logic        out_valid_q, out_valid_d;
  logic        out_rs_q, out_last_q;
  logic [3:0]  out_nib_q;

  logic out_ready, emit, cur_free;

  assign out_ready = !out_valid_q || pop;
  assign emit      = cur_valid_q && out_ready;
  // The current entry is free once its low nibble goes out.
  assign cur_free  = !cur_valid_q || (emit && phase_q);
  assign q_pop_o   = cur_free && !q_empty_i;

  always_comb begin
    cur_valid_d = cur_valid_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q && !pop;
    if (emit) begin
      out_valid_d = 1'b1;
      phase_d     = !phase_q;
      if (phase_q) begin
        cur_valid_d = 1'b0;
      end
    end
    if (q_pop_o) begin
      cur_valid_d = 1'b1;
      phase_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_entry_i;
    end
    if (emit) begin
      out_rs_q   <= cur_q.rs;
      out_nib_q  <= phase_q ? cur_q.value[3:0] : cur_q.value[7:4];
      out_last_q <= phase_q && cur_q.last;
    end
  end

  assign empty             = !out_valid_q;
  assign register_select_o = out_rs_q;
  assign nibble_o          = out_nib_q;
  assign last_o            = out_last_q;

endmodule : cln_back
`default_nettype wire

FILE: design/char_lcd_nibble_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer: 4-bit character LCD writer
// Turns text, cursor and raw byte items into register-select and nibble
// transfers while tracking the cursor position.
// ----------------------------------------------------------------------------
// The first nibble of an item passes the byte queue, the back end's current-entry
// register and the output register before it is shown. The output register gives
// one nibble per cycle while pop is held and bytes are queued; an item is two or four nibbles.
// The front end makes one or two bytes per item; full is raised while a second byte waits.
// Reset clears the cursor to column 0, row 0 and empties all queues.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer import cln_pkg::*; #(
  parameter int unsigned COLUMNS = DefColumns,
  parameter int unsigned ROWS    = DefRows
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  operation_i,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic [5:0]  target_column_i,
  input  wire logic [2:0]  target_row_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             register_select_o,
  output logic [3:0]       nibble_o,
  output logic             last_o
);

  logic        q_push, q_full, q_pop, q_empty;
  byte_entry_t q_wr_entry, q_rd_entry;

  cln_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .operation_i    (operation_i),
    .byte_value_i   (byte_value_i),
    .target_column_i(target_column_i),
    .target_row_i   (target_row_i),
    .q_push_o       (q_push),
    .q_entry_o      (q_wr_entry),
    .q_full_i       (q_full)
  );

  cln_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_wr_entry),
    .full_o (q_full),
    .pop_i  (q_pop),
    .entry_o(q_rd_entry),
    .empty_o(q_empty)
  );

  cln_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_entry_i        (q_rd_entry),
    .q_empty_i        (q_empty),
    .q_pop_o          (q_pop),
    .empty            (empty),
    .pop              (pop),
    .register_select_o(register_select_o),
    .nibble_o         (nibble_o),
    .last_o           (last_o)
  );

  // The byte queue is never written while full nor read while empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_full))
    else $error("byte queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_pop && q_empty))
    else $error("byte queue underflow");

  // An accepted item always finds room in the queue for its first byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (push && !full) |-> q_push)
    else $error("accepted item not queued");

endmodule : char_lcd_nibble_writer
`default_nettype wire

FILE: test/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the character LCD nibble writer
// Sends text, cursor and raw byte items through the push/full side and pops
// nibble transfers from the empty/pop side. A cursor-tracking predictor
// builds the expected transfers for each accepted item, and every popped
// transfer is checked against the oldest one in line. Directed tests cover
// raw bytes, cursor moves, control characters and line wrap. They are
// followed by a back-pressure test and random traffic under changing idle
// rates.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cln_pkg::*;

  localparam int unsigned LcdColumns  = 16;
  localparam int unsigned LcdRows     = 2;
  localparam int          StallLimit  = 2000;
  localparam int          DrainCycles = 8;
  localparam int          MaxPrinted  = 40;

  localparam logic [7:0] SetDdramAddr = 8'h80;
  localparam logic [6:0] LineOffset [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

  typedef struct packed {
    logic       rs;
    logic [3:0] nibble;
    logic       is_last;
  } lcd_xfer_t;

  logic       clk_i             = 1'b0;
  logic       rst_ni            = 1'b0;
  logic       push              = 1'b0;
  logic       full;
  logic [1:0] operation_i       = 2'd0;
  logic [7:0] byte_value_i      = 8'h00;
  logic [5:0] target_column_i   = 6'd0;
  logic [2:0] target_row_i      = 3'd0;
  logic       empty;
  logic       pop               = 1'b0;
  logic       register_select_o;
  logic [3:0] nibble_o;
  logic       last_o;

  // Predicted cursor and the transfers still to come out of the block.
  logic [5:0] cur_col = 6'd0;
  logic [1:0] cur_row = 2'd0;
  lcd_xfer_t  pending_xfers [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  int items_sent    = 0;
  int xfers_checked = 0;
  int mismatches    = 0;

  char_lcd_nibble_writer #(
    .COLUMNS(LcdColumns),
    .ROWS   (LcdRows)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .operation_i      (operation_i),
    .byte_value_i     (byte_value_i),
    .target_column_i  (target_column_i),
    .target_row_i     (target_row_i),
    .empty            (empty),
    .pop              (pop),
    .register_select_o(register_select_o),
    .nibble_o         (nibble_o),
    .last_o           (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  task automatic queue_lcd_byte(logic rs, logic [7:0] value);
    pending_xfers.push_back('{rs: rs, nibble: value[7:4], is_last: 1'b0});
    pending_xfers.push_back('{rs: rs, nibble: value[3:0], is_last: 1'b0});
  endtask

  task automatic move_cursor(int col, int row);
    logic [6:0] addr;
    if (row >= LcdRows) row = 0;
    cur_col = col[5:0];
    cur_row = row[1:0];
    addr = {1'b0, cur_col} + LineOffset[cur_row];
    queue_lcd_byte(RsInstr, SetDdramAddr | {1'b0, addr});
  endtask

  task automatic predict_transfers(op_e op, logic [7:0] value, logic [5:0] col,
                                   logic [2:0] row);
    case (op)
      OP_TEXT: begin
        // A character, newline or return past the last column wraps first.
        if (cur_col >= LcdColumns) move_cursor(0, int'(cur_row) + 1);
        if (value == CharLf) begin
          move_cursor(int'(cur_col), int'(cur_row) + 1);
        end else if (value == CharCr) begin
          move_cursor(0, int'(cur_row));
        end else begin
          queue_lcd_byte(RsData, value);
          cur_col = cur_col + 6'd1;
        end
      end
      OP_SET_CUR: move_cursor(int'(col), int'(row));
      OP_RAW_CMD: queue_lcd_byte(RsInstr, value);
      default:    queue_lcd_byte(RsData, value);
    endcase
    pending_xfers[pending_xfers.size() - 1].is_last = 1'b1;
  endtask

  // ------------------------------------------------------------ sender side

  task automatic send_item(op_e op, logic [7:0] value, logic [5:0] col,
                           logic [2:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push            <= 1'b1;
    operation_i     <= op;
    byte_value_i    <= value;
    target_column_i <= col;
    target_row_i    <= row;
    // Values read right after the edge are the ones the block sampled.
    do @(posedge clk_i); while (full);
    predict_transfers(op, value, col, row);
    items_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_xfers.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------- receiver side

  task automatic report_mismatch(string msg);
    if (mismatches < MaxPrinted) $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_transfer(logic rs, logic [3:0] nib, logic lst);
    lcd_xfer_t want;
    if (pending_xfers.size() == 0) begin
      report_mismatch($sformatf("transfer rs=%0b nibble=%h last=%0b not expected",
                                rs, nib, lst));
    end else begin
      want = pending_xfers.pop_front();
      if (rs !== want.rs)
        report_mismatch($sformatf("register_select %0b, expected %0b", rs, want.rs));
      if (nib !== want.nibble)
        report_mismatch($sformatf("nibble %h, expected %h", nib, want.nibble));
      if (lst !== want.is_last)
        report_mismatch($sformatf("last %0b, expected %0b", lst, want.is_last));
    end
    xfers_checked++;
  endtask

  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) check_transfer(register_select_o, nibble_o, last_o);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Ends the run when neither side has made a handshake for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("Watchdog: no handshake for %0d cycles", StallLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  // ------------------------------------------------------------------ tests

  task automatic test_raw_bytes();
    send_item(OP_RAW_CMD, 8'h00, 6'd0, 3'd0);
    send_item(OP_RAW_CMD, 8'hFF, 6'd63, 3'd7);
    send_item(OP_RAW_DAT, 8'hA5, 6'd0, 3'd0);
    send_item(OP_RAW_DAT, 8'h5A, 6'd63, 3'd7);
    wait_drained();
  endtask

  task automatic test_set_cursor();
    send_item(OP_SET_CUR, 8'hFF, 6'd63, 3'd7);  // row past the end becomes 0
    send_item(OP_SET_CUR, 8'h00, 6'd0, 3'd0);
    send_item(OP_SET_CUR, 8'h00, 6'd15, 3'd1);
    send_item(OP_SET_CUR, 8'h00, 6'd63, 3'd1);  // address reaches 127, the top of the range
    send_item(OP_SET_CUR, 8'h00, 6'd5, 3'd3);
    wait_drained();
  endtask

  task automatic test_text_controls();
    send_item(OP_SET_CUR, 8'h00, 6'd3, 3'd0);
    send_item(OP_TEXT, 8'h00, 6'd0, 3'd0);      // zero byte prints as data
    send_item(OP_TEXT, 8'hFF, 6'd0, 3'd0);
    send_item(OP_TEXT, CharLf, 6'd0, 3'd0);
    send_item(OP_TEXT, CharLf, 6'd0, 3'd0);     // second row wraps to the first
    send_item(OP_TEXT, CharCr, 6'd0, 3'd0);
    wait_drained();
  endtask

  task automatic test_line_wrap();
    send_item(OP_SET_CUR, 8'h00, 6'd14, 3'd1);
    send_item(OP_TEXT, 8'h41, 6'd0, 3'd0);
    send_item(OP_TEXT, 8'h42, 6'd0, 3'd0);
    send_item(OP_TEXT, 8'h43, 6'd0, 3'd0);      // past the last column: wraps
    send_item(OP_SET_CUR, 8'h00, 6'd40, 3'd0);
    send_item(OP_TEXT, CharLf, 6'd0, 3'd0);     // wrap, then newline
    send_item(OP_SET_CUR, 8'h00, 6'd16, 3'd1);
    send_item(OP_TEXT, CharCr, 6'd0, 3'd0);     // wrap, then return
    wait_drained();
  endtask

  task automatic send_random_item();
    logic [7:0] value;
    logic [5:0] col;
    logic [2:0] row;
    int         pick;
    op_e        op;
    value = 8'($urandom_range(255));
    col   = 6'($urandom_range(63));
    row   = 3'($urandom_range(7));
    pick  = $urandom_range(99);
    op    = OP_TEXT;
    if (pick < 55) begin
      op = OP_TEXT;
    end else if (pick < 65) begin
      value = CharLf;
    end else if (pick < 71) begin
      value = CharCr;
    end else if (pick < 83) begin
      op = OP_SET_CUR;
      // Mostly columns near the visible line, so wraps follow soon.
      if ($urandom_range(3) != 0) col = 6'($urandom_range(LcdColumns));
    end else if (pick < 92) begin
      op = OP_RAW_CMD;
    end else begin
      op = OP_RAW_DAT;
    end
    send_item(op, value, col, row);
  endtask

  task automatic test_fill_and_stall();
    send_idle_pct = 0;
    hold_left = 150;
    for (int i = 0; i < 20; i++) send_random_item();
    wait_drained();
  endtask

  task automatic test_random_traffic(int count, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) send_random_item();
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 19;
    recv_idle_pct = 82;
    test_raw_bytes();
    test_set_cursor();
    test_text_controls();
    test_line_wrap();
    test_fill_and_stall();
    test_random_traffic(54, 19, 82);
    test_random_traffic(54, 82, 19);
    test_random_traffic(53, 0, 0);

    $display("Sent %0d items and checked %0d nibble transfers, %0d mismatches.",
             items_sent, xfers_checked, mismatches);
    $display("Covered raw bytes, cursor moves, newline, return, wrap and back-pressure.");
    if (mismatches == 0 && pending_xfers.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule : tb_top
`default_nettype wire

FILE: char_lcd_nibble_writer.f
design/cln_pkg.sv
design/cln_front.sv
design/cln_queue.sv
design/cln_back.sv
design/char_lcd_nibble_writer.sv
test/tb_top.sv
